[rtl/nsel_pkg.sv]
// Shared types and constants for the top-N selection block.
package nsel_pkg;

  // Field widths of the item and result beats
  localparam int TAG_W    = 32;
  localparam int WEIGHT_W = 32;
  localparam int KEY_W    = 16;
  localparam int SEL_W    = 5;
  localparam int RANK_W   = 4;

  // Reset value of the select count register
  localparam logic [SEL_W-1:0] SEL_RESET = 5'd16;

  // One candidate beat
  typedef struct packed {
    logic [TAG_W-1:0]           item_tag;
    logic signed [WEIGHT_W-1:0] weight;
    logic [KEY_W-1:0]           tie_key;
    logic                       last;
  } in_item_t;

  // One result beat
  typedef struct packed {
    logic [TAG_W-1:0]  chosen_tag;
    logic [RANK_W-1:0] rank;
    logic              final_res;
  } out_item_t;

  // Contents of one store slot
  typedef struct packed {
    logic [TAG_W-1:0]           tag;
    logic signed [WEIGHT_W-1:0] weight;
    logic [KEY_W-1:0]           key;
    logic                       valid;
  } slot_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the candidate
    logic shl;  // shift toward the head (emission)
    logic clr;  // drop all entries
  } cell_ctl_t;

endpackage

[rtl/nsel_cell.sv]
// One slot of the sorted chain: compare against the candidate and shift.
module nsel_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  nsel_pkg::cell_ctl_t ctl_i,
  input  nsel_pkg::slot_t    cand_i,
  input  nsel_pkg::slot_t    left_i,
  input  logic               left_ahead_i,
  input  nsel_pkg::slot_t    right_i,
  output nsel_pkg::slot_t    slot_o,
  output logic               ahead_o
);

  nsel_pkg::slot_t slot_r;
  nsel_pkg::slot_t slot_nxt;
  logic            w_gt;
  logic            w_eq;
  logic            k_lt;

  // Candidate ranks ahead of this slot (an empty slot always loses)
  assign w_gt    = $signed(cand_i.weight) > $signed(slot_r.weight);
  assign w_eq    = cand_i.weight == slot_r.weight;
  assign k_lt    = cand_i.key < slot_r.key;
  assign ahead_o = !slot_r.valid || w_gt || (w_eq && k_lt);

  // Next slot contents
  always_comb begin
    slot_nxt = slot_r;
    if (ctl_i.clr) begin
      slot_nxt.valid = 1'b0;
    end else if (ctl_i.shl) begin
      slot_nxt = right_i;
    end else if (ctl_i.ins) begin
      if (left_ahead_i) begin
        slot_nxt = left_i;
      end else if (ahead_o) begin
        slot_nxt = cand_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.valid <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_o = slot_r;

endmodule

[rtl/top_n_select_random_ties.sv]
// Top level of the streaming top-N selection block with keyed tie break.
//
// Usage:
//   Candidates arrive on in_item and are taken at a clock edge where start
//   is high and busy is low. Each beat is inserted into a chain of CAPACITY
//   cells kept sorted by weight (highest first), then tie key (lowest first),
//   then arrival. Ordinary candidates are taken one per cycle, back to back.
//   A beat with last set is inserted too; busy then rises and the chain
//   shifts toward its head once per cycle, emitting
//   min(select_count, CAPACITY, candidates kept) tags in rank order.
//   Busy stays high through the emit state, after which the
//   store is empty and the next run may start.
//   Each result beat shows on out_item for exactly one cycle with out_strobe
//   high; out_strobe and out_item are registered from the emit state, which
//   the edge that takes the last beat enters.
//   The receiver cannot stall; every strobed beat is taken.
//   The user must write select_count via cfg_we/cfg_wdata only while idle;
//   the block does not enforce it. Synchronous reset empties the store, sets
//   select_count to 16 and drops busy and out_strobe.
module top_n_select_random_ties #(
  parameter int CAPACITY = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  nsel_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output nsel_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [nsel_pkg::SEL_W-1:0]     cfg_wdata
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > nsel_pkg::SEL_W) ? CNT_W : nsel_pkg::SEL_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t                        state_r, state_nxt;
  logic [CNT_W-1:0]              seen_r, seen_nxt;
  logic [CNT_W-1:0]              remain_r, remain_nxt;
  logic [nsel_pkg::RANK_W-1:0]   rank_r, rank_nxt;
  logic [nsel_pkg::SEL_W-1:0]    sel_cnt_r;
  logic                          out_strobe_r, out_strobe_nxt;
  nsel_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                          in_acc;
  logic [CNT_W-1:0]              seen_after;
  logic [CMP_W-1:0]              lim_cap;
  logic [CMP_W-1:0]              lim_sel;
  logic [CMP_W-1:0]              lim_cnt;
  logic [CMP_W-1:0]              lim_a;
  logic [CMP_W-1:0]              lim_b;
  nsel_pkg::cell_ctl_t           ctl;
  nsel_pkg::slot_t               cand;

  nsel_pkg::slot_t               slot_s  [CAPACITY];
  nsel_pkg::slot_t               left_s  [CAPACITY];
  nsel_pkg::slot_t               right_s [CAPACITY];
  logic [CAPACITY-1:0]           ahead_s;
  logic [CAPACITY-1:0]           left_ahead_s;
  logic [CAPACITY-1:0]           valid_vec;

  assign busy   = (state_r == ST_EMIT);
  assign in_acc = start && !busy;

  // Candidate as a slot image
  always_comb begin
    cand.tag    = in_item.item_tag;
    cand.weight = in_item.weight;
    cand.key    = in_item.tie_key;
    cand.valid  = 1'b1;
  end

  // Count after this insertion, saturating at capacity
  assign seen_after = (seen_r == CNT_W'(CAPACITY)) ? seen_r : seen_r + 1'b1;

  // Emit count: min(select_count, capacity, kept)
  assign lim_cap = CMP_W'(CAPACITY);
  assign lim_sel = CMP_W'(sel_cnt_r);
  assign lim_cnt = CMP_W'(seen_after);
  assign lim_a   = (lim_sel < lim_cap) ? lim_sel : lim_cap;
  assign lim_b   = (lim_a < lim_cnt) ? lim_a : lim_cnt;

  // Sequencer: insert, emit from the head, clear
  always_comb begin
    state_nxt      = state_r;
    seen_nxt       = seen_r;
    remain_nxt     = remain_r;
    rank_nxt       = rank_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    ctl            = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ctl.ins  = 1'b1;
          seen_nxt = seen_after;
          if (in_item.last) begin
            state_nxt  = ST_EMIT;
            remain_nxt = CNT_W'(lim_b);
            rank_nxt   = '0;
          end
        end
      end
      ST_EMIT: begin
        if (remain_r != '0) begin
          ctl.shl                   = 1'b1;
          out_strobe_nxt            = 1'b1;
          out_item_nxt.chosen_tag   = slot_s[0].tag;
          out_item_nxt.rank         = rank_r;
          out_item_nxt.final_res    = (remain_r == CNT_W'(1));
          remain_nxt                = remain_r - 1'b1;
          rank_nxt                  = rank_r + 1'b1;
        end
        if (remain_r <= CNT_W'(1)) begin
          ctl.clr   = 1'b1;
          seen_nxt  = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      seen_r       <= '0;
      remain_r     <= '0;
      rank_r       <= '0;
      out_strobe_r <= 1'b0;
      sel_cnt_r    <= nsel_pkg::SEL_RESET;
    end else begin
      state_r      <= state_nxt;
      seen_r       <= seen_nxt;
      remain_r     <= remain_nxt;
      rank_r       <= rank_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_we) begin
        sel_cnt_r <= cfg_wdata;
      end
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Chain of sorted cells
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign left_s[gi]       = '0;
        assign left_ahead_s[gi] = 1'b0;
      end else begin : g_mid
        assign left_s[gi]       = slot_s[gi-1];
        assign left_ahead_s[gi] = ahead_s[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_tail
        assign right_s[gi] = '0;
      end else begin : g_body
        assign right_s[gi] = slot_s[gi+1];
      end
      assign valid_vec[gi] = slot_s[gi].valid;

      nsel_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl_i        (ctl),
        .cand_i       (cand),
        .left_i       (left_s[gi]),
        .left_ahead_i (left_ahead_s[gi]),
        .right_i      (right_s[gi]),
        .slot_o       (slot_s[gi]),
        .ahead_o      (ahead_s[gi])
      );
    end
  endgenerate

  // A result beat only follows an emitting cycle
  a_strobe_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(state_r == ST_EMIT))
    else $error("result beat without an emitting cycle");

  // The final beat of a run is never followed directly by another beat
  a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.final_res) |=> !out_strobe)
    else $error("result beat after the final one");

  // While idle the kept count matches the valid prefix of the chain
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(valid_vec) == int'(seen_r)))
    else $error("kept count and valid slots disagree");

endmodule
